>>> rtl/core/lrup_pkg.sv
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared widths, reset values and the lookup bundle passed from the frame
// table to the top level.
// ----------------------------------------------------------------------------
package lrup_pkg;

  // Field widths fixed by the interface
  localparam int PAGE_W  = 16;
  localparam int SLOT_W  = 3;
  localparam int FAULT_W = 32;
  localparam int CFG_W   = 4;

  // Packed stream widths; the data widths are rounded up to whole bytes
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 56;
  localparam int OUT_TUSER_W  = 2;

  // Frames in use after reset
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // Saturation value of the fault counter
  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  // Outcome of one frame search
  typedef struct packed {
    logic              hit;
    logic              evicted_valid;
    logic [SLOT_W-1:0] slot;
    logic [PAGE_W-1:0] evicted_page;
  } lrup_lookup_t;

endpackage

>>> rtl/core/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// LRU page replacement
// Fully associative frame set with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each page request word gives exactly one result word. A word is taken into
// an input register, searched against all active frames in one combinational
// pass (parallel page compare, lowest empty frame, oldest-stamp comparison
// tree) and its result is loaded into an output register, so the block
// sustains one request per clock while the result stream does not stall. The
// output register lets a new request in while a result waits; the combinational
// frame search is the critical path. frames_in_use is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle, which
// the block itself does not enforce; 0 acts as 1 and values above FRAMES act
// as FRAMES. No clearing pass is needed after reset.
module lru_page_replacement
  import lrup_pkg::*;
#(
  parameter int FRAMES     = 8,
  parameter int STAMP_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_wdata,     // frames_in_use
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [15:0] page
  input  logic                   s_axis_tuser,  // new_run
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [2:0] slot, [18:3] evicted_page,
                                                // [50:19] fault_count, rest zero
  output logic [OUT_TUSER_W-1:0] m_axis_tuser   // [0] hit, [1] evicted_valid
);

  logic [CFG_W-1:0]      frames_in_use;
  logic                  in_valid;
  logic [PAGE_W-1:0]     in_page;
  logic                  in_new_run;
  logic                  adv;
  logic [STAMP_BITS-1:0] time_now;
  logic [STAMP_BITS-1:0] time_eff;
  logic [STAMP_BITS-1:0] time_now_next;
  logic [FAULT_W-1:0]    faults;
  logic [FAULT_W-1:0]    faults_eff;
  logic [FAULT_W-1:0]    faults_next;
  lrup_lookup_t          lookup;
  logic                  out_valid;
  logic                  out_hit;
  logic                  out_ev_valid;
  logic [SLOT_W-1:0]     out_slot;
  logic [PAGE_W-1:0]     out_ev_page;
  logic [FAULT_W-1:0]    out_faults;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= CFG_RESET;
    end else if (cfg_we) begin
      frames_in_use <= cfg_wdata;
    end
  end

  // Handshake: a word moves on when the output register is free or draining
  assign adv           = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_page    <= s_axis_tdata[PAGE_W-1:0];
      in_new_run <= s_axis_tuser;
    end
  end

  // Frame search and update
  lrup_frame_table #(
    .FRAMES     (FRAMES),
    .STAMP_BITS (STAMP_BITS)
  ) u_table (
    .clk           (clk),
    .rst           (rst),
    .frames_in_use (frames_in_use),
    .clear         (in_new_run),
    .upd           (adv),
    .page          (in_page),
    .stamp         (time_eff),
    .lookup        (lookup)
  );

  // Saturating time and fault counters, restarted by a new run
  always_comb begin
    time_eff      = in_new_run ? '0 : time_now;
    faults_eff    = in_new_run ? '0 : faults;
    time_now_next = (time_eff == '1) ? time_eff : time_eff + STAMP_BITS'(1);
    if (!lookup.hit && (faults_eff != FAULT_MAX)) begin
      faults_next = faults_eff + FAULT_W'(1);
    end else begin
      faults_next = faults_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now <= '0;
      faults   <= '0;
    end else if (adv) begin
      time_now <= time_now_next;
      faults   <= faults_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit      <= lookup.hit;
      out_ev_valid <= lookup.evicted_valid;
      out_slot     <= lookup.slot;
      out_ev_page  <= lookup.evicted_page;
      out_faults   <= faults_next;
    end
  end

  // Output packing
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_W'({out_faults, out_ev_page, out_slot});
  assign m_axis_tuser  = {out_ev_valid, out_hit};

endmodule

>>> rtl/core/lrup_frame_table.sv
// ----------------------------------------------------------------------------
// LRU frame table
// Holds the frames and searches them in one pass: page match, lowest empty
// frame and oldest stamp through a comparison tree. Updates the chosen frame.
// ----------------------------------------------------------------------------
module lrup_frame_table
  import lrup_pkg::*;
#(
  parameter int FRAMES     = 8,
  parameter int STAMP_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [CFG_W-1:0]      frames_in_use,
  input  logic                  clear,
  input  logic                  upd,
  input  logic [PAGE_W-1:0]     page,
  input  logic [STAMP_BITS-1:0] stamp,
  output lrup_lookup_t          lookup
);

  localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int LEAVES = 1 << IDX_W;
  localparam int CNT_W  = $clog2(FRAMES + 1);
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [PAGE_W-1:0]     frame_page  [FRAMES];
  logic [STAMP_BITS-1:0] frame_stamp [FRAMES];
  logic [FRAMES-1:0]     frame_valid;

  logic [CMP_W-1:0]  cfg_ext;
  logic [CMP_W-1:0]  n_active;
  logic [FRAMES-1:0] active;
  logic [FRAMES-1:0] eff_valid;
  logic [FRAMES-1:0] match;
  logic [FRAMES-1:0] empty;
  logic [IDX_W-1:0]  hit_idx;
  logic [IDX_W-1:0]  empty_idx;
  logic [IDX_W-1:0]  lru_idx;
  logic [IDX_W-1:0]  victim_idx;
  logic              hit;
  logic              empty_any;
  logic              evict;
  logic [SLOT_W+IDX_W-1:0] slot_ext;

  logic                  node_ok    [1:2*LEAVES-1];
  logic [STAMP_BITS-1:0] node_stamp [1:2*LEAVES-1];
  logic [IDX_W-1:0]      node_idx   [1:2*LEAVES-1];

  // Clamp the active frame count to 1..FRAMES
  always_comb begin
    cfg_ext = CMP_W'(frames_in_use);
    if (cfg_ext == '0) begin
      n_active = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(FRAMES)) begin
      n_active = CMP_W'(FRAMES);
    end else begin
      n_active = cfg_ext;
    end
  end

  // A new run sees every frame as empty
  assign eff_valid = clear ? '0 : frame_valid;

  // Per-frame match and empty flags
  for (genvar i = 0; i < FRAMES; i++) begin : g_frame
    assign active[i] = CMP_W'(i) < n_active;
    assign match[i]  = active[i] && eff_valid[i] && (frame_page[i] == page);
    assign empty[i]  = active[i] && !eff_valid[i];
  end

  // Lowest matching frame and lowest empty frame
  always_comb begin
    hit_idx   = '0;
    empty_idx = '0;
    for (int j = FRAMES - 1; j >= 0; j--) begin
      if (match[j]) begin
        hit_idx = IDX_W'(j);
      end
      if (empty[j]) begin
        empty_idx = IDX_W'(j);
      end
    end
  end

  assign hit       = |match;
  assign empty_any = |empty;

  // Leaves of the oldest-stamp tree; padding leaves never win
  for (genvar l = 0; l < LEAVES; l++) begin : g_leaf
    if (l < FRAMES) begin : g_real
      assign node_ok[LEAVES+l]    = active[l];
      assign node_stamp[LEAVES+l] = frame_stamp[l];
    end else begin : g_pad
      assign node_ok[LEAVES+l]    = 1'b0;
      assign node_stamp[LEAVES+l] = '0;
    end
    assign node_idx[LEAVES+l] = IDX_W'(l);
  end

  // Tree nodes: the right child wins only on a strictly smaller stamp,
  // so ties go to the lower frame index.
  for (genvar k = 1; k < LEAVES; k++) begin : g_node
    logic pick_r;
    assign pick_r = node_ok[2*k+1] &&
                    (!node_ok[2*k] || (node_stamp[2*k+1] < node_stamp[2*k]));
    assign node_ok[k]    = node_ok[2*k] || node_ok[2*k+1];
    assign node_stamp[k] = pick_r ? node_stamp[2*k+1] : node_stamp[2*k];
    assign node_idx[k]   = pick_r ? node_idx[2*k+1] : node_idx[2*k];
  end

  assign lru_idx = node_idx[1];

  // Choose the frame to use
  assign evict      = !hit && !empty_any;
  assign victim_idx = hit ? hit_idx : (empty_any ? empty_idx : lru_idx);
  assign slot_ext   = {SLOT_W'(0), victim_idx};

  always_comb begin
    lookup.hit           = hit;
    lookup.evicted_valid = evict;
    lookup.slot          = slot_ext[SLOT_W-1:0];
    lookup.evicted_page  = evict ? frame_page[lru_idx] : '0;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
    end else if (upd) begin
      frame_valid <= eff_valid | (FRAMES'(1) << victim_idx);
    end
  end

  // Frame contents
  always_ff @(posedge clk) begin
    if (upd) begin
      frame_stamp[victim_idx] <= stamp;
      if (!hit) begin
        frame_page[victim_idx] <= page;
      end
    end
  end

endmodule

>>> rtl/core/lrup_checker.sv
// ----------------------------------------------------------------------------
// LRU page replacement checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module lrup_checker
  import lrup_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

  // A stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // No result is offered in the cycle after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1])
    else $error("eviction reported on a hit");

  // The evicted page reads zero when nothing was evicted
  a_evict_page: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[18:3] == 16'd0)
    else $error("evicted page set without an eviction");

  // A fault is always counted
  a_fault_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[50:19] != 32'd0)
    else $error("fault count zero on a fault");

endmodule

bind lru_page_replacement lrup_checker u_lrup_checker (.*);

>>> verif/lru_page_replacement_test.sv
// ----------------------------------------------------------------------------
// LRU page replacement testbench
// Sends page requests into the block and compares every result word with a
// behavioural copy of the frame table kept here. Directed tests cover filling,
// hits, eviction order and the limits of frames_in_use, including a count
// changed in the middle of a run. Random phases follow with working sets of
// varying size, noise pages and restarts. Both stream sides stall at random
// except in the closing phases.
// ----------------------------------------------------------------------------
module lru_page_replacement_test;
  import lrup_pkg::*;

  localparam int N_FRAMES = 8;
  localparam int N_PHASES = 12;

  // One result word, unpacked into its fields
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted_valid;
    logic [PAGE_W-1:0] evicted_page;
    logic [FAULT_W-1:0] fault_count;
  } lookup_result_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_W-1:0]       cfg_wdata;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [15:0] page
  logic                   s_axis_tuser;   // new_run
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [2:0] slot, [18:3] evicted_page,
                                          // [50:19] fault_count, rest zero
  logic [OUT_TUSER_W-1:0] m_axis_tuser;   // [0] hit, [1] evicted_valid

  // Frame table copy used for prediction
  logic [PAGE_W-1:0]  table_page  [N_FRAMES];
  logic               table_valid [N_FRAMES];
  logic [31:0]        table_stamp [N_FRAMES];
  logic [31:0]        table_time;
  logic [FAULT_W-1:0] table_faults;
  logic [CFG_W-1:0]   table_frames_cfg;

  lookup_result_t expected_lookups [$];
  int unsigned    mismatch_count;
  int unsigned    result_count;
  bit             stall_on;

  lru_page_replacement u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock with a period of two time units.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Works out the result of one request and updates the frame table copy.
  function automatic lookup_result_t predict_lookup(input logic [PAGE_W-1:0] page,
                                                    input logic new_run);
    lookup_result_t r;
    int active;
    int idx;
    bit found;
    r = '0;
    if (new_run) begin
      for (int i = 0; i < N_FRAMES; i++) table_valid[i] = 1'b0;
      table_time   = '0;
      table_faults = '0;
    end
    // A count of zero behaves as one; anything above the frame count is capped.
    if (table_frames_cfg == 0) active = 1;
    else if (table_frames_cfg > N_FRAMES) active = N_FRAMES;
    else active = int'(table_frames_cfg);
    idx   = 0;
    found = 1'b0;
    for (int i = 0; i < active; i++) begin
      if (!found && table_valid[i] && table_page[i] == page) begin
        found = 1'b1;
        idx   = i;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      table_stamp[idx] = table_time;
    end else begin
      if (table_faults != FAULT_MAX) table_faults = table_faults + FAULT_W'(1);
      for (int i = 0; i < active; i++) begin
        if (!found && !table_valid[i]) begin
          found = 1'b1;
          idx   = i;
        end
      end
      // No empty frame: replace the oldest stamp, the lowest index on a tie.
      if (!found) begin
        idx = 0;
        for (int i = 1; i < active; i++) begin
          if (table_stamp[i] < table_stamp[idx]) idx = i;
        end
        r.evicted_valid = 1'b1;
        r.evicted_page  = table_page[idx];
      end
      table_page[idx]  = page;
      table_valid[idx] = 1'b1;
      table_stamp[idx] = table_time;
    end
    if (table_time != '1) table_time = table_time + 32'd1;
    r.slot        = idx[SLOT_W-1:0];
    r.fault_count = table_faults;
    return r;
  endfunction

  // Prints one line per mismatch and counts every one.
  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("MISMATCH word %0d %s: expected %0h, got %0h", result_count, field,
             want, got);
    mismatch_count++;
  endtask

  // Sends one request word, with an optional random gap in front of it.
  task automatic send_request(input logic [PAGE_W-1:0] page, input logic new_run);
    if (stall_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= page;
    s_axis_tuser  <= new_run;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_lookups.push_back(predict_lookup(page, new_run));
  endtask

  // Stops sending and waits until every expected word has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes frames_in_use; only called with the block idle.
  task automatic write_frames(input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    table_frames_cfg = value;
  endtask

  // All eight frames: fill, hit, then evict by age.
  task automatic test_fill_and_evict();
    write_frames(4'd8);
    send_request(16'h0000, 1'b1);
    send_request(16'hFFFF, 1'b0);
    for (int p = 2; p < N_FRAMES; p++) send_request(PAGE_W'(p), 1'b0);
    // Refresh frame 0 so that frame 1 becomes the oldest.
    send_request(16'h0000, 1'b0);
    send_request(16'h8000, 1'b0);
    send_request(16'h0002, 1'b0);
    send_request(16'h7FFF, 1'b0);
    drain_results();
  endtask

  // Limits of frames_in_use and a count changed during a run.
  task automatic test_frame_limits();
    write_frames(4'd1);
    send_request(16'h1234, 1'b1);
    send_request(16'h1234, 1'b0);
    send_request(16'h5678, 1'b0);
    drain_results();
    // Zero acts as a single frame.
    write_frames(4'd0);
    send_request(16'hAAAA, 1'b0);
    drain_results();
    // All ones is capped at the frame count.
    write_frames(4'd15);
    send_request(16'h5555, 1'b0);
    send_request(16'hAAAA, 1'b0);
    drain_results();
    // Frame 1 is hidden now, so its page misses and replaces frame 0.
    write_frames(4'd1);
    send_request(16'h5555, 1'b0);
    drain_results();
    // Frame 1 comes back; the lowest matching frame must win.
    write_frames(4'd8);
    send_request(16'h5555, 1'b0);
    send_request(16'h0F0F, 1'b0);
    drain_results();
  endtask

  // Random phases of working-set traffic with noise and restarts.
  task automatic test_random_traffic();
    logic [PAGE_W-1:0] pool [12];
    int pool_n;
    int items_left;
    int run_len;
    logic [CFG_W-1:0] frames;
    logic [PAGE_W-1:0] page;
    logic new_run;
    for (int phase = 0; phase < N_PHASES; phase++) begin
      stall_on = (phase < N_PHASES - 2);
      if ($urandom_range(0, 3) == 0) frames = CFG_W'($urandom_range(0, 15));
      else frames = CFG_W'($urandom_range(1, 8));
      write_frames(frames);
      items_left = $urandom_range(100, 110);
      while (items_left > 0) begin
        // Each run works on a small set of pages; some runs keep the old frames.
        pool_n = $urandom_range(1, 12);
        for (int i = 0; i < pool_n; i++) pool[i] = PAGE_W'($urandom);
        run_len = $urandom_range(8, 40);
        new_run = ($urandom_range(0, 3) != 0);
        for (int k = 0; k < run_len && items_left > 0; k++) begin
          if ($urandom_range(0, 9) == 0) page = PAGE_W'($urandom);
          else page = pool[$urandom_range(0, pool_n - 1)];
          if (k != 0) new_run = ($urandom_range(0, 49) == 0);
          send_request(page, new_run);
          items_left--;
        end
      end
      drain_results();
    end
  endtask

  // Receiver side: ready drops in random bursts while stalling is on.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Compares each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_lookups.size() == 0) begin
        report_mismatch("unexpected word", '0, 64'(m_axis_tdata));
      end else begin
        want = expected_lookups.pop_front();
        if (m_axis_tuser[0] !== want.hit)
          report_mismatch("hit", 64'(want.hit), 64'(m_axis_tuser[0]));
        if (m_axis_tdata[2:0] !== want.slot)
          report_mismatch("slot", 64'(want.slot), 64'(m_axis_tdata[2:0]));
        if (m_axis_tuser[1] !== want.evicted_valid)
          report_mismatch("evicted_valid", 64'(want.evicted_valid),
                          64'(m_axis_tuser[1]));
        if (m_axis_tdata[18:3] !== want.evicted_page)
          report_mismatch("evicted_page", 64'(want.evicted_page),
                          64'(m_axis_tdata[18:3]));
        if (m_axis_tdata[50:19] !== want.fault_count)
          report_mismatch("fault_count", 64'(want.fault_count),
                          64'(m_axis_tdata[50:19]));
        if (m_axis_tdata[OUT_TDATA_W-1:51] !== '0)
          report_mismatch("padding", '0, 64'(m_axis_tdata[OUT_TDATA_W-1:51]));
      end
      result_count++;
    end
  end

  // Hard limit on run time.
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // Reset, then the tests in turn.
  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = '0;
    s_axis_tuser     = 1'b0;
    stall_on         = 1'b1;
    mismatch_count   = 0;
    result_count     = 0;
    table_frames_cfg = CFG_RESET;
    table_time       = '0;
    table_faults     = '0;
    for (int i = 0; i < N_FRAMES; i++) begin
      table_page[i]  = '0;
      table_valid[i] = 1'b0;
      table_stamp[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_fill_and_evict();
    test_frame_limits();
    test_random_traffic();

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
